FILE: rtl/core/edmd_pkg.sv
`timescale 1ns / 1ps

package edmd_pkg;

    localparam int Q_W      = 24;
    localparam int TERM_W   = 39;
    localparam int SUM_W    = 42;
    localparam int DIV_BITS = 42;
    localparam int CNT_W    = 3;

    localparam logic [Q_W-1:0]    Q_ONE     = 24'h100000;
    localparam logic [Q_W-1:0]    Q_MAX     = 24'hFFFFFF;
    localparam logic [TERM_W-1:0] TERM_LIM  = 39'h40_0000_0000;
    localparam logic [CNT_W-1:0]  MAX_COUNT = 3'd7;

    localparam logic [1:0] CFG_POLE         = 2'd0;
    localparam logic [1:0] CFG_EVENT_FACTOR = 2'd1;
    localparam logic [1:0] CFG_KERNEL_LEN   = 2'd2;

    typedef struct packed {
        logic sweep_wr;
        logic take_in;
        logic head_clr;
        logic head_wr;
        logic term_init;
        logic ser_lo;
        logic ser_hi;
        logic div_init;
        logic div_step;
        logic mean_load;
        logic gain_lo;
        logic gain_hi;
        logic rd_tap;
        logic tap_start;
        logic pow_step;
        logic tap_wr;
        logic out_load;
        logic head_inc;
    } edmd_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic tap_last;
    } edmd_sts_t;

    function automatic logic [Q_W-1:0] sat_round(input logic [2*Q_W-1:0] prod);
        logic [2*Q_W:0] s;
        begin
            s = {1'b0, prod} + 49'd524288;
            if (|s[48:44])
                return Q_MAX;
            return s[43:20];
        end
    endfunction

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        begin
            return (c > MAX_COUNT) ? MAX_COUNT : c;
        end
    endfunction

endpackage

FILE: rtl/core/edmd_datapath.sv
`timescale 1ns / 1ps

module edmd_datapath #(
    parameter int MAX_TAPS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  edmd_pkg::edmd_cmd_t                  cmd,
    input  logic [15:0]                          pole,
    input  logic [edmd_pkg::Q_W-1:0]             event_factor,
    input  logic [10:0]                          kernel_len,
    input  logic [edmd_pkg::CNT_W-1:0]           event_count,
    output edmd_pkg::edmd_sts_t                  sts,
    output logic [edmd_pkg::Q_W-1:0]             gain,
    output logic                                 saturated
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int KW = $clog2(MAX_TAPS + 1);
    localparam int LW = (KW > 11) ? KW : 11;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic [LW-1:0] LEN_MAX   = LW'(MAX_TAPS);

    logic [edmd_pkg::Q_W-1:0] mem [MAX_TAPS];
    logic [edmd_pkg::Q_W-1:0] rd_data_reg;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic                     wr_en;
    logic [edmd_pkg::Q_W-1:0] wr_data;

    logic [AW-1:0] head_reg;
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] kidx_reg;
    logic [LW-1:0] kcnt_reg;
    logic [LW-1:0] len_eff;
    logic [AW-1:0] head_plus;

    logic [edmd_pkg::CNT_W-1:0]  cnt_reg;
    logic [edmd_pkg::TERM_W-1:0] term_mag_reg;
    logic                        term_neg_reg;
    logic signed [edmd_pkg::SUM_W-1:0] sum_reg;
    logic [24:0]                 low_reg;
    logic [edmd_pkg::SUM_W-1:0]  dq_reg;
    logic [2:0]                  rem_reg;
    logic [edmd_pkg::TERM_W-1:0] mean_mag_reg;
    logic                        mean_neg_reg;
    logic [edmd_pkg::Q_W-1:0]    entry_reg;
    logic [edmd_pkg::Q_W-1:0]    res_gain_reg;
    logic                        res_sat_reg;
    logic [edmd_pkg::Q_W-1:0]    gain_reg;
    logic                        sat_reg;
    logic [edmd_pkg::Q_W-1:0]    p_reg;
    logic [edmd_pkg::Q_W-1:0]    d_mag_reg;
    logic                        d_neg_reg;

    logic                        r_neg;
    logic [edmd_pkg::Q_W-1:0]    r_mag;
    logic [edmd_pkg::Q_W-1:0]    tap;
    logic [edmd_pkg::Q_W-1:0]    mul_a;
    logic [edmd_pkg::Q_W-1:0]    mul_b;
    logic [2*edmd_pkg::Q_W-1:0]  mul_p;
    logic [48:0]                 low_sum;
    logic [44:0]                 wide;
    logic [39:0]                 d_prod;
    logic [40:0]                 d_round;
    logic signed [edmd_pkg::SUM_W-1:0] term_s;
    logic [edmd_pkg::SUM_W-1:0]  sum_abs;
    logic [3:0]                  div_t;
    logic                        div_ge;
    logic [edmd_pkg::Q_W-1:0]    d_mag_next;

    assign r_neg = event_factor > edmd_pkg::Q_ONE;
    assign r_mag = r_neg ? (event_factor - edmd_pkg::Q_ONE) : (edmd_pkg::Q_ONE - event_factor);
    assign tap   = d_neg_reg ? (edmd_pkg::Q_ONE - d_mag_reg) : (edmd_pkg::Q_ONE + d_mag_reg);

    always_comb
    begin
        if (kernel_len == 11'd0)
            len_eff = LW'(1);
        else if (LW'(kernel_len) > LEN_MAX)
            len_eff = LEN_MAX;
        else
            len_eff = LW'(kernel_len);
    end

    assign head_plus = (head_reg == LAST_ADDR) ? '0 : head_reg + AW'(1);

    always_comb
    begin
        if (cmd.ser_lo)
        begin
            mul_a = {4'b0, term_mag_reg[19:0]};
            mul_b = r_mag;
        end
        else if (cmd.ser_hi)
        begin
            mul_a = {5'b0, term_mag_reg[38:20]};
            mul_b = r_mag;
        end
        else if (cmd.gain_lo)
        begin
            mul_a = {4'b0, mean_mag_reg[19:0]};
            mul_b = entry_reg;
        end
        else if (cmd.gain_hi)
        begin
            mul_a = {5'b0, mean_mag_reg[38:20]};
            mul_b = entry_reg;
        end
        else if (cmd.pow_step)
        begin
            mul_a = p_reg;
            mul_b = tap;
        end
        else
        begin
            mul_a = rd_data_reg;
            mul_b = p_reg;
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign low_sum = {1'b0, mul_p} + 49'd524288;
    assign wide    = {1'b0, mul_p[43:0]} + {20'b0, low_reg};

    assign d_prod     = d_mag_reg * pole;
    assign d_round    = {1'b0, d_prod} + 41'd32768;
    assign d_mag_next = d_round[39:16];

    assign term_s  = term_neg_reg ? -$signed({3'b0, term_mag_reg})
                                  : $signed({3'b0, term_mag_reg});
    assign sum_abs = sum_reg[edmd_pkg::SUM_W-1] ? 42'(-sum_reg) : 42'(sum_reg);

    assign div_t  = {rem_reg, dq_reg[edmd_pkg::SUM_W-1]};
    assign div_ge = div_t >= {1'b0, cnt_reg};

    always_comb
    begin
        rd_addr = cmd.rd_tap ? kidx_reg : head_reg;
        wr_en   = 1'b1;
        wr_addr = sweep_reg;
        wr_data = edmd_pkg::Q_ONE;
        if (cmd.sweep_wr)
        begin
            wr_addr = sweep_reg;
        end
        else if (cmd.head_wr)
        begin
            wr_addr = head_reg;
        end
        else if (cmd.tap_wr)
        begin
            wr_addr = kidx_reg;
            wr_data = edmd_pkg::sat_round(mul_p);
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            if (cmd.sweep_wr)
                sweep_reg <= (sweep_reg == LAST_ADDR) ? '0 : sweep_reg + AW'(1);
            if (cmd.head_clr)
                head_reg <= '0;
            else if (cmd.head_inc)
                head_reg <= head_plus;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
            cnt_reg <= edmd_pkg::clamp_count(event_count);
        if (cmd.head_wr)
        begin
            entry_reg    <= rd_data_reg;
            res_gain_reg <= rd_data_reg;
            res_sat_reg  <= 1'b0;
        end
        if (cmd.term_init)
        begin
            term_mag_reg <= 39'(edmd_pkg::Q_ONE);
            term_neg_reg <= 1'b0;
            sum_reg      <= '0;
            d_neg_reg    <= event_factor < edmd_pkg::Q_ONE;
            d_mag_reg    <= (event_factor < edmd_pkg::Q_ONE) ? (edmd_pkg::Q_ONE - event_factor)
                                                             : (event_factor - edmd_pkg::Q_ONE);
            kidx_reg     <= head_plus;
            kcnt_reg     <= LW'(1);
        end
        if (cmd.ser_lo)
        begin
            sum_reg <= sum_reg + term_s;
            low_reg <= low_sum[44:20];
        end
        if (cmd.gain_lo)
            low_reg <= low_sum[44:20];
        if (cmd.ser_hi)
        begin
            term_mag_reg <= (wide > 45'(edmd_pkg::TERM_LIM)) ? edmd_pkg::TERM_LIM : wide[38:0];
            term_neg_reg <= term_neg_reg ^ r_neg;
        end
        if (cmd.div_init)
        begin
            dq_reg  <= sum_abs + {39'b0, cnt_reg >> 1};
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[edmd_pkg::SUM_W-2:0], div_ge};
            rem_reg <= div_ge ? 3'(div_t - {1'b0, cnt_reg}) : div_t[2:0];
        end
        if (cmd.mean_load)
        begin
            mean_mag_reg <= (dq_reg > 42'(edmd_pkg::TERM_LIM)) ? edmd_pkg::TERM_LIM
                                                               : dq_reg[38:0];
            mean_neg_reg <= sum_reg[edmd_pkg::SUM_W-1];
        end
        if (cmd.gain_hi)
        begin
            if (mean_neg_reg && (wide != '0))
            begin
                res_gain_reg <= '0;
                res_sat_reg  <= 1'b1;
            end
            else if (wide > 45'(edmd_pkg::Q_MAX))
            begin
                res_gain_reg <= edmd_pkg::Q_MAX;
                res_sat_reg  <= 1'b1;
            end
            else
            begin
                res_gain_reg <= wide[23:0];
                res_sat_reg  <= 1'b0;
            end
        end
        if (cmd.tap_start)
            p_reg <= edmd_pkg::Q_ONE;
        if (cmd.pow_step)
            p_reg <= edmd_pkg::sat_round(mul_p);
        if (cmd.tap_wr)
        begin
            d_mag_reg <= d_mag_next;
            kidx_reg  <= (kidx_reg == LAST_ADDR) ? '0 : kidx_reg + AW'(1);
            kcnt_reg  <= kcnt_reg + LW'(1);
        end
        if (cmd.out_load)
        begin
            gain_reg <= res_gain_reg;
            sat_reg  <= res_sat_reg;
        end
    end

    assign sts.sweep_last = sweep_reg == LAST_ADDR;
    assign sts.tap_last   = kcnt_reg == len_eff;
    assign gain           = gain_reg;
    assign saturated      = sat_reg;

endmodule

FILE: rtl/core/edmd_ctrl.sv
`timescale 1ns / 1ps

module edmd_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [edmd_pkg::CNT_W-1:0] event_count,
    input  logic                       restart,
    input  logic                       out_stall,
    input  edmd_pkg::edmd_sts_t        sts,
    output logic                       in_stall,
    output logic                       out_valid,
    output edmd_pkg::edmd_cmd_t        cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_FETCH,
        S_ENTRY,
        S_SLO,
        S_SHI,
        S_DINIT,
        S_DSTEP,
        S_MEAN,
        S_GLO,
        S_GHI,
        S_TRD,
        S_POW,
        S_TWR,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic                       out_valid_reg;
    logic [edmd_pkg::CNT_W-1:0] cnt_reg;
    logic [edmd_pkg::CNT_W-1:0] j_reg;
    logic [5:0]                 bit_reg;
    logic                       accept;
    logic                       out_free;
    logic                       j_last;

    assign accept   = (state_reg == S_IDLE) && in_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign j_last   = j_reg == (cnt_reg - edmd_pkg::CNT_W'(1));

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_INIT, S_CLEAR: cmd.sweep_wr = 1'b1;
            S_IDLE:
            begin
                cmd.take_in  = accept;
                cmd.head_clr = accept && restart;
            end
            S_FETCH: ;
            S_ENTRY:
            begin
                cmd.head_wr   = 1'b1;
                cmd.term_init = 1'b1;
            end
            S_SLO:   cmd.ser_lo    = 1'b1;
            S_SHI:   cmd.ser_hi    = 1'b1;
            S_DINIT: cmd.div_init  = 1'b1;
            S_DSTEP: cmd.div_step  = 1'b1;
            S_MEAN:  cmd.mean_load = 1'b1;
            S_GLO:   cmd.gain_lo   = 1'b1;
            S_GHI:   cmd.gain_hi   = 1'b1;
            S_TRD:
            begin
                cmd.rd_tap    = 1'b1;
                cmd.tap_start = 1'b1;
            end
            S_POW:
            begin
                cmd.rd_tap   = 1'b1;
                cmd.pow_step = 1'b1;
            end
            S_TWR:
            begin
                cmd.rd_tap = 1'b1;
                cmd.tap_wr = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = out_free;
                cmd.head_inc = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            j_reg         <= '0;
            bit_reg       <= '0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_INIT:
                    if (sts.sweep_last)
                        state_reg <= S_IDLE;
                S_IDLE:
                    if (accept)
                    begin
                        cnt_reg   <= edmd_pkg::clamp_count(event_count);
                        state_reg <= restart ? S_CLEAR : S_ENTRY;
                    end
                S_CLEAR:
                    if (sts.sweep_last)
                        state_reg <= S_FETCH;
                S_FETCH: state_reg <= S_ENTRY;
                S_ENTRY:
                begin
                    j_reg     <= '0;
                    state_reg <= (cnt_reg == '0) ? S_DONE : S_SLO;
                end
                S_SLO: state_reg <= S_SHI;
                S_SHI:
                begin
                    j_reg     <= j_reg + edmd_pkg::CNT_W'(1);
                    state_reg <= j_last ? S_DINIT : S_SLO;
                end
                S_DINIT:
                begin
                    bit_reg   <= '0;
                    state_reg <= S_DSTEP;
                end
                S_DSTEP:
                begin
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'(edmd_pkg::DIV_BITS - 1))
                        state_reg <= S_MEAN;
                end
                S_MEAN: state_reg <= S_GLO;
                S_GLO:  state_reg <= S_GHI;
                S_GHI:  state_reg <= S_TRD;
                S_TRD:
                begin
                    j_reg     <= '0;
                    state_reg <= S_POW;
                end
                S_POW:
                begin
                    j_reg <= j_reg + edmd_pkg::CNT_W'(1);
                    if (j_last)
                        state_reg <= S_TWR;
                end
                S_TWR: state_reg <= sts.tap_last ? S_DONE : S_TRD;
                S_DONE:
                    if (out_free)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/event_driven_multiplicative_depression.sv
`timescale 1ns / 1ps
// A word with no events skips the series, division and tap update and goes to S_DONE.
// A word with c events runs the series, division and gain, then updates L taps,
// L = effective kernel length, the shared 24x24 multiplier walking the window one tap at a time.
// A restart word first refills the window with ones in a sweep over all MAX_TAPS entries.
// Reset: asynchronous, active low; the window is then filled with ones by a
// sweep over all entries, during which no input word is accepted.
module event_driven_multiplicative_depression #(
    parameter int MAX_TAPS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  event_count,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] gain,
    output logic        saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    logic [15:0] pole_reg;
    logic [23:0] event_factor_reg;
    logic [10:0] kernel_len_reg;

    edmd_pkg::edmd_cmd_t cmd;
    edmd_pkg::edmd_sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_reg         <= '0;
            event_factor_reg <= edmd_pkg::Q_ONE;
            kernel_len_reg   <= 11'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                edmd_pkg::CFG_POLE:         pole_reg         <= cfg_data[15:0];
                edmd_pkg::CFG_EVENT_FACTOR: event_factor_reg <= cfg_data;
                edmd_pkg::CFG_KERNEL_LEN:   kernel_len_reg   <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    edmd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .event_count (event_count),
        .restart     (restart),
        .out_stall   (out_stall),
        .sts         (sts),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .cmd         (cmd)
    );

    edmd_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pole         (pole_reg),
        .event_factor (event_factor_reg),
        .kernel_len   (kernel_len_reg),
        .event_count  (event_count),
        .sts          (sts),
        .gain         (gain),
        .saturated    (saturated)
    );

endmodule

FILE: rtl/core/edmd_checker.sv
`timescale 1ns / 1ps

module edmd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] gain,
    input logic        saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gain) && $stable(saturated))
        else $error("result word changed while stalled");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (gain == 24'h000000) || (gain == 24'hFFFFFF))
        else $error("saturated flag without clamped gain");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted on consecutive cycles");

    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !(out_valid && !$past(out_valid)))
        else $error("result appeared one cycle after acceptance");

endmodule

bind event_driven_multiplicative_depression edmd_checker u_edmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gain      (gain),
    .saturated (saturated)
);
